@@ rtl/set_assoc_hash_table_with_aging_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative hash table
// Shared clocking and reset gating for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_HASH_TABLE_WITH_AGING_TOP_MACROS_SVH
`define SET_ASSOC_HASH_TABLE_WITH_AGING_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SAHTA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sahta: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SAHTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sahta: next-cycle check failed");

`endif

@@ rtl/sahta_pkg.sv @@
// ----------------------------------------------------------------------------
// sahta_pkg
// Types, codes and default sizes shared by the hash table modules.
// ----------------------------------------------------------------------------
package sahta_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DefIndexBits = 10;
  localparam int DefWays      = 4;
  localparam int DefMaxScore  = 32000;

  // Fixed field widths.
  localparam int TagW  = 32;
  localparam int AgeW  = 6;
  localparam int PayW  = 48;
  localparam int WordW = TagW + PayW;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_PROBE      = 2'd0,
    OP_STORE      = 2'd1,
    OP_NEW_SEARCH = 2'd2
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WRITE,
    ST_FINISH
  } state_e;

  // One stored way payload, move in the lowest bits.
  typedef struct packed {
    logic        [5:0]  age;
    logic        [1:0]  bound;
    logic signed [7:0]  depth;
    logic signed [15:0] score;
    logic        [15:0] move;
  } entry_t;

  // Decisions of the way evaluator for one way.
  typedef struct packed {
    logic tag_hit;    // stored tag equals the key tag
    logic probe_hit;  // tag matches and the way is not empty
    logic take;       // way replaces the current store candidate
  } eval_t;

endpackage

@@ rtl/sahta_ram.sv @@
// ----------------------------------------------------------------------------
// sahta_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sahta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sahta_way_eval.sv @@
// ----------------------------------------------------------------------------
// sahta_way_eval
// Compare unit shared by all ways: tag match, empty test and the victim rule.
// ----------------------------------------------------------------------------
module sahta_way_eval import sahta_pkg::*; (
  input  logic [TagW-1:0] ent_tag_i,
  input  entry_t          ent_i,
  input  logic [TagW-1:0] key_tag_i,
  input  logic            first_i,
  input  entry_t          pick_i,
  input  logic [AgeW-1:0] age_i,
  output eval_t           eval_o
);

  logic ent_empty;
  logic pick_empty;
  logic older;
  logic shallower;

  // A way with bound none counts as empty.
  assign ent_empty  = (ent_i.bound == 2'd0);
  assign pick_empty = (pick_i.bound == 2'd0);

  // The new way is from another generation while the candidate is current.
  assign older     = (ent_i.age != age_i) && (pick_i.age == age_i);
  // Same generation, and the new way holds a smaller depth.
  assign shallower = (ent_i.age == pick_i.age) && (ent_i.depth < pick_i.depth);

  always_comb begin
    eval_o.tag_hit   = (ent_tag_i == key_tag_i);
    eval_o.probe_hit = eval_o.tag_hit && !ent_empty;
    eval_o.take      = first_i || (!pick_empty && (ent_empty || older || shallower));
  end

endmodule

@@ rtl/set_assoc_hash_table_with_aging_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_hash_table_with_aging_top
// Set-associative hash table with generation aging and depth replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on the s_axis channel: tuser carries the operation
//   (probe, store, new search), tdata the key and the entry to store. Each
//   beat gives exactly one result beat on the m_axis channel: tuser holds
//   hit and written, tdata the stored entry of a probe hit, else zeros.
//   The ways of one bucket sit in one RAM, one way per word, and a single
//   compare unit looks at them one at a time: each way takes a read state
//   and an evaluate state. A probe reads the ways up to the hitting way, all
//   WAYS on a miss, then finishes; a store reads all WAYS, or fewer when an
//   earlier way holds the same tag, then passes the write state; a new search
//   or an unused code goes straight to the finish state. The block takes
//   one beat at a time; the next beat is accepted from the cycle in which
//   the result first sits in the output register.
//   After reset a clearing pass writes zeros to all 2**INDEX_BITS*WAYS RAM
//   words, one word a cycle (4096 words by default), and the generation
//   restarts at zero; no beat is accepted meanwhile. A stalled receiver holds
//   the result in the output register; the next item is accepted and worked
//   on, and waits before its result until that register drains.
// ----------------------------------------------------------------------------
module set_assoc_hash_table_with_aging_top import sahta_pkg::*; #(
  parameter int INDEX_BITS = DefIndexBits,
  parameter int WAYS       = DefWays,
  parameter int MAX_SCORE  = DefMaxScore
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Fields from bit 0: key[63:0], search_depth[71:64], score_in[87:72],
  // bound_kind[89:88], best_move[105:90], zero fill [111:106].
  input  logic [111:0] s_axis_tdata_i,
  // Fields from bit 0: operation[1:0].
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // Fields from bit 0: move_out[15:0], score_out[31:16], depth_out[39:32],
  // bound_out[41:40], age_out[47:42].
  output logic [47:0]  m_axis_tdata_o,
  // Fields from bit 0: hit[0], written[1].
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);

  localparam int Slots  = (1 << INDEX_BITS) * WAYS;
  localparam int AddrW  = $clog2(Slots);
  localparam int WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;

  state_e                 state_q, state_d;
  logic [AddrW-1:0]       clr_q, clr_d;
  logic [AgeW-1:0]        age_q, age_d;
  op_e                    op_q, op_d;
  logic [TagW-1:0]        tag_q, tag_d;
  logic [AddrW-1:0]       base_q, base_d;
  logic signed [7:0]      depth_q, depth_d;
  logic signed [15:0]     score_q, score_d;
  logic [1:0]             bound_q, bound_d;
  logic [15:0]            move_q, move_d;
  logic [WayW-1:0]        way_q, way_d;
  logic [WayW-1:0]        pick_q, pick_d;
  entry_t                 pick_ent_q, pick_ent_d;
  logic                   pick_match_q, pick_match_d;
  logic                   res_hit_q, res_hit_d;
  logic                   res_wr_q, res_wr_d;
  entry_t                 res_ent_q, res_ent_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_hit_q, out_hit_d;
  logic                   out_wr_q, out_wr_d;
  entry_t                 out_ent_q, out_ent_d;

  logic                   ram_we, ram_re;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [WordW-1:0]       ram_wdata, ram_rdata;
  entry_t                 rd_ent;
  logic [TagW-1:0]        rd_tag;
  eval_t                  ev;
  logic                   last_way;
  logic                   skip;
  logic signed [15:0]     max_s;
  logic signed [15:0]     clamped;
  entry_t                 new_ent;

  // Bucket RAM, one way per word: tag above the payload.
  sahta_ram #(
    .Width (WordW),
    .Depth (Slots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata[PayW-1:0]);
  assign rd_tag = ram_rdata[WordW-1:PayW];

  // Shared compare unit for the way that was just read.
  sahta_way_eval u_eval (
    .ent_tag_i (rd_tag),
    .ent_i     (rd_ent),
    .key_tag_i (tag_q),
    .first_i   (way_q == '0),
    .pick_i    (pick_ent_q),
    .age_i     (age_q),
    .eval_o    (ev)
  );

  assign last_way  = (way_q == WayW'(WAYS - 1));
  assign ram_raddr = AddrW'(base_q + AddrW'(way_q));

  // Skip the store when a deeper entry of this generation owns the tag.
  assign skip = pick_match_q && (pick_ent_q.age == age_q) && (pick_ent_q.depth > depth_q);

  // Score clamp to the allowed window.
  assign max_s = 16'(MAX_SCORE);
  always_comb begin
    if (score_q > max_s) begin
      clamped = max_s;
    end else if (score_q < -max_s) begin
      clamped = -max_s;
    end else begin
      clamped = score_q;
    end
  end

  always_comb begin
    new_ent.age   = age_q;
    new_ent.bound = bound_q;
    new_ent.depth = depth_q;
    new_ent.score = clamped;
    new_ent.move  = move_q;
  end

  // Sequencer: next state, datapath updates and RAM control.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    age_d        = age_q;
    op_d         = op_q;
    tag_d        = tag_q;
    base_d       = base_q;
    depth_d      = depth_q;
    score_d      = score_q;
    bound_d      = bound_q;
    move_d       = move_q;
    way_d        = way_q;
    pick_d       = pick_q;
    pick_ent_d   = pick_ent_q;
    pick_match_d = pick_match_q;
    res_hit_d    = res_hit_q;
    res_wr_d     = res_wr_q;
    res_ent_d    = res_ent_q;
    out_hit_d    = out_hit_q;
    out_wr_d     = out_wr_q;
    out_ent_d    = out_ent_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = clr_q;
    ram_wdata    = '0;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = AddrW'(clr_q + 1'b1);
        if (clr_q == AddrW'(Slots - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          tag_d        = s_axis_tdata_i[63:32];
          base_d       = AddrW'(AddrW'(s_axis_tdata_i[INDEX_BITS-1:0]) * AddrW'(WAYS));
          depth_d      = s_axis_tdata_i[71:64];
          score_d      = s_axis_tdata_i[87:72];
          bound_d      = s_axis_tdata_i[89:88];
          move_d       = s_axis_tdata_i[105:90];
          way_d        = '0;
          pick_d       = '0;
          pick_match_d = 1'b0;
          res_hit_d    = 1'b0;
          res_wr_d     = 1'b0;
          res_ent_d    = '0;
          unique case (s_axis_tuser_i)
            OP_PROBE: begin
              op_d    = OP_PROBE;
              state_d = ST_READ;
            end
            OP_STORE: begin
              op_d    = OP_STORE;
              state_d = ST_READ;
            end
            OP_NEW_SEARCH: begin
              age_d   = AgeW'(age_q + 1'b1);
              state_d = ST_FINISH;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        way_d = WayW'(way_q + 1'b1);
        if (op_q == OP_PROBE) begin
          if (ev.probe_hit) begin
            res_hit_d = 1'b1;
            res_ent_d = rd_ent;
            state_d   = ST_FINISH;
          end else if (last_way) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_READ;
          end
        end else begin
          if (ev.tag_hit) begin
            pick_d       = way_q;
            pick_ent_d   = rd_ent;
            pick_match_d = 1'b1;
            state_d      = ST_WRITE;
          end else begin
            if (ev.take) begin
              pick_d     = way_q;
              pick_ent_d = rd_ent;
            end
            state_d = last_way ? ST_WRITE : ST_READ;
          end
        end
      end
      ST_WRITE: begin
        ram_we    = !skip;
        ram_waddr = AddrW'(base_q + AddrW'(pick_q));
        ram_wdata = {tag_q, new_ent};
        res_wr_d  = !skip;
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_hit_d   = res_hit_q;
          out_wr_d    = res_wr_q;
          out_ent_d   = res_ent_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      age_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      age_q       <= age_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tag_q        <= tag_d;
    base_q       <= base_d;
    depth_q      <= depth_d;
    score_q      <= score_d;
    bound_q      <= bound_d;
    move_q       <= move_d;
    way_q        <= way_d;
    pick_q       <= pick_d;
    pick_ent_q   <= pick_ent_d;
    pick_match_q <= pick_match_d;
    res_hit_q    <= res_hit_d;
    res_wr_q     <= res_wr_d;
    res_ent_q    <= res_ent_d;
    out_hit_q    <= out_hit_d;
    out_wr_q     <= out_wr_d;
    out_ent_q    <= out_ent_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_ent_q;
  assign m_axis_tuser_o  = {out_wr_q, out_hit_q};

endmodule

@@ rtl/sahta_checker.sv @@
// ----------------------------------------------------------------------------
// sahta_checker
// Port-level checks of the hash table result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "set_assoc_hash_table_with_aging_top_macros.svh"

module sahta_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [47:0] m_axis_tdata_i,
  input logic [1:0]  m_axis_tuser_i,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i
);

  // A stalled result beat stays valid and keeps its data.
  `SAHTA_ASSERT_NEXT(a_hold, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))

  // A result is never both a probe hit and a store write.
  `SAHTA_ASSERT_IMPL(a_excl, m_axis_tvalid_i, !(m_axis_tuser_i[0] && m_axis_tuser_i[1]))

  // Without a hit the entry fields are all zero.
  `SAHTA_ASSERT_IMPL(a_miss_zero, m_axis_tvalid_i && !m_axis_tuser_i[0], m_axis_tdata_i == 48'd0)

  // A hit never reports an empty way.
  `SAHTA_ASSERT_IMPL(a_hit_bound, m_axis_tvalid_i && m_axis_tuser_i[0], m_axis_tdata_i[41:40] != 2'd0)

endmodule

bind set_assoc_hash_table_with_aging_top sahta_checker u_sahta_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

@@ test/set_assoc_hash_table_with_aging_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_hash_table_with_aging_top_tb
// Streams probe, store and new search beats into the hash table and checks
// every result beat against a shadow copy of the buckets kept in the bench.
// ----------------------------------------------------------------------------
module set_assoc_hash_table_with_aging_top_tb;
  import sahta_pkg::*;

  localparam int IndexBits   = DefIndexBits;
  localparam int Ways        = DefWays;
  localparam int MaxScore    = DefMaxScore;
  localparam int Slots       = (1 << IndexBits) * Ways;
  localparam int ClkPeriod   = 12;
  localparam int ResetCycles = 10;
  localparam int RandomItems = 430;
  localparam int TagPoolSize = 6;
  localparam int PhaseLen    = 150;
  localparam int HoldAt      = 330;
  localparam int HoldCycles  = 250;
  localparam int TailCycles  = 50;
  localparam int MaxReports  = 10;

  // Operation code with no meaning; the block must answer with all zeros.
  localparam logic [1:0] OpReserved = 2'd3;

  // Bound kinds of a stored entry.
  localparam logic [1:0] BoundNone  = 2'd0;
  localparam logic [1:0] BoundUpper = 2'd1;
  localparam logic [1:0] BoundLower = 2'd2;
  localparam logic [1:0] BoundExact = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic signed [15:0] score;
    logic [1:0]         bound;
    logic [15:0]        move;
    logic               wait_drain;  // hold this beat until all results are back
  } table_req_t;

  typedef struct packed {
    logic   hit;
    logic   written;
    entry_t data;
  } table_rsp_t;

  logic         clk_i;
  logic         rst_ni;
  logic [111:0] s_axis_tdata_i;
  logic [1:0]   s_axis_tuser_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [47:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;

  // Shadow copy of the table contents and the generation counter.
  logic [31:0] shadow_tag [Slots];
  entry_t      shadow_entry [Slots];
  logic [5:0]  shadow_age;

  table_req_t req_q [$];
  table_rsp_t pending_rsp_q [$];

  int   accepted_count = 0;
  int   mismatch_count = 0;
  int   rx_hold_left   = 0;
  bit   rx_hold_done   = 0;
  logic in_beat_taken  = 1'b0;

  set_assoc_hash_table_with_aging_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Hard limit on the run length.
  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [63:0] bucket_key(input logic [31:0] tag,
                                             input logic [IndexBits-1:0] bucket);
    return {tag, {(32 - IndexBits){1'b0}}, bucket};
  endfunction

  task automatic queue_req(input logic [1:0] op, input logic [63:0] key,
                           input logic signed [7:0] depth,
                           input logic signed [15:0] score, input logic [1:0] bound,
                           input logic [15:0] move, input logic wait_drain);
    table_req_t req;
    req.op         = op;
    req.key        = key;
    req.depth      = depth;
    req.score      = score;
    req.bound      = bound;
    req.move       = move;
    req.wait_drain = wait_drain;
    req_q.push_back(req);
  endtask

  // Applies one operation to the shadow table and returns the result it gives.
  task automatic apply_to_shadow_table(input table_req_t req, output table_rsp_t rsp);
    int                 base;
    int                 pick;
    logic [31:0]        tag;
    bit                 found;
    entry_t             cand;
    entry_t             cur;
    logic signed [15:0] clamped;
    rsp  = '0;
    base = int'(req.key[IndexBits-1:0]) * Ways;
    tag  = req.key[63:32];
    case (req.op)
      OP_PROBE: begin
        // First way in order with a matching tag and a real bound.
        found = 1'b0;
        for (int w = 0; w < Ways; w++) begin
          if (!found && shadow_tag[base + w] == tag &&
              shadow_entry[base + w].bound != BoundNone) begin
            found    = 1'b1;
            rsp.hit  = 1'b1;
            rsp.data = shadow_entry[base + w];
          end
        end
      end
      OP_STORE: begin
        // Victim: same tag, else empty, else older generation, else shallowest.
        pick  = 0;
        found = 1'b0;
        for (int w = 0; w < Ways; w++) begin
          cand = shadow_entry[base + w];
          cur  = shadow_entry[base + pick];
          if (!found) begin
            if (shadow_tag[base + w] == tag) begin
              pick  = w;
              found = 1'b1;
            end else if (w != 0 && cur.bound != BoundNone) begin
              if (cand.bound == BoundNone) begin
                pick = w;
              end else if (cand.age != shadow_age && cur.age == shadow_age) begin
                pick = w;
              end else if (cand.age == cur.age &&
                           $signed(cand.depth) < $signed(cur.depth)) begin
                pick = w;
              end
            end
          end
        end
        cur = shadow_entry[base + pick];
        // A deeper entry of the same tag from this generation is kept.
        if (shadow_tag[base + pick] == tag && cur.age == shadow_age &&
            $signed(cur.depth) > $signed(req.depth)) begin
          rsp.written = 1'b0;
        end else begin
          clamped = req.score;
          if (req.score > MaxScore) begin
            clamped = 16'(MaxScore);
          end else if (req.score < -MaxScore) begin
            clamped = 16'(-MaxScore);
          end
          shadow_tag[base + pick]   = tag;
          shadow_entry[base + pick] = '{age: shadow_age, bound: req.bound,
                                        depth: req.depth, score: clamped,
                                        move: req.move};
          rsp.written = 1'b1;
        end
      end
      OP_NEW_SEARCH: begin
        shadow_age = shadow_age + 6'd1;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      end
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    logic [31:0]           tag_pool [TagPoolSize];
    logic [IndexBits-1:0]  bucket_pool [4];
    logic [63:0]           key;
    logic [31:0]           mid;
    logic [1:0]            op;
    logic signed [7:0]     depth;
    logic signed [15:0]    score;
    int                    roll;

    rst_ni          = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    s_axis_tvalid_i = 1'b0;
    m_axis_tready_i = 1'b0;
    shadow_age      = '0;
    for (int s = 0; s < Slots; s++) begin
      shadow_tag[s]   = '0;
      shadow_entry[s] = '0;
    end

    // Directed beats, mostly on one bucket: empty ways, skips, clamps and eviction.
    queue_req(OP_PROBE, bucket_key(32'h0, 10'd5), 0, 0, BoundNone, 16'h0, 1'b0);
    queue_req(OP_STORE, bucket_key(32'h0, 10'd5), -5, 100, BoundExact, 16'h0, 1'b0);
    queue_req(OP_STORE, bucket_key(32'h0, 10'd5), 0, 7, BoundNone, 16'h1, 1'b0);
    queue_req(OP_PROBE, bucket_key(32'h0, 10'd5), 0, 0, BoundNone, 16'h0, 1'b0);
    queue_req(OP_STORE, bucket_key(32'hFFFF_FFFF, 10'd5), 127, 32767, BoundExact,
              16'hFFFF, 1'b0);
    queue_req(OP_PROBE, bucket_key(32'hFFFF_FFFF, 10'd5), 0, 0, BoundNone, 16'h0, 1'b0);
    queue_req(OP_STORE, bucket_key(32'hFFFF_FFFF, 10'd5), -128, -32768, BoundUpper,
              16'h5A5A, 1'b0);
    queue_req(OP_STORE, bucket_key(32'hFFFF_FFFF, 10'd5), 127, -32768, BoundLower,
              16'h0, 1'b0);
    queue_req(OP_PROBE, bucket_key(32'hFFFF_FFFF, 10'd5), 0, 0, BoundNone, 16'h0, 1'b0);
    queue_req(OP_STORE, bucket_key(32'h1111_1111, 10'd5), 3, 11, BoundUpper, 16'h11, 1'b0);
    queue_req(OP_STORE, bucket_key(32'h2222_2222, 10'd5), -5, 22, BoundLower, 16'h22, 1'b0);
    queue_req(OP_STORE, bucket_key(32'h3333_3333, 10'd5), 10, 33, BoundExact, 16'h33, 1'b0);
    queue_req(OP_STORE, bucket_key(32'h4444_4444, 10'd5), 1, 44, BoundExact, 16'h44, 1'b0);
    queue_req(OP_PROBE, bucket_key(32'h2222_2222, 10'd5), 0, 0, BoundNone, 16'h0, 1'b0);
    queue_req(OP_NEW_SEARCH, 64'h0, 0, 0, BoundNone, 16'h0, 1'b0);
    queue_req(OP_STORE, bucket_key(32'h5555_5555, 10'd5), -128, 55, BoundUpper,
              16'h55, 1'b0);
    queue_req(OP_PROBE, bucket_key(32'h4444_4444, 10'd5), 0, 0, BoundNone, 16'h0, 1'b0);
    queue_req(OpReserved, '1, -1, -1, BoundExact, 16'hFFFF, 1'b0);
    queue_req(OP_STORE, '1, 1, 1, BoundUpper, 16'h1234, 1'b0);
    queue_req(OP_PROBE, '1, 0, 0, BoundNone, 16'h0, 1'b1);
    queue_req(OP_PROBE, 64'h0, 0, 0, BoundNone, 16'h0, 1'b0);

    // Random beats mostly land on a few buckets and tags to force conflicts.
    tag_pool[0] = 32'h0;
    tag_pool[1] = 32'hFFFF_FFFF;
    for (int t = 2; t < TagPoolSize; t++) tag_pool[t] = $urandom;
    bucket_pool[0] = '0;
    bucket_pool[1] = '1;
    bucket_pool[2] = IndexBits'($urandom);
    bucket_pool[3] = IndexBits'($urandom);
    for (int i = 0; i < RandomItems; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        op = OP_PROBE;
      end else if (roll < 80) begin
        op = OP_STORE;
      end else if (roll < 95) begin
        op = OP_NEW_SEARCH;
      end else begin
        op = OpReserved;
      end
      mid = $urandom;
      if ($urandom_range(9) == 0) begin
        key = {$urandom, $urandom};
      end else begin
        key = {tag_pool[$urandom_range(TagPoolSize - 1)], mid[31:IndexBits],
               bucket_pool[$urandom_range(3)]};
      end
      depth = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(16) - 8);
      score = 16'($urandom);
      queue_req(op, key, depth, score, 2'($urandom_range(3)), 16'($urandom),
                (i % PhaseLen) == PhaseLen / 2);
    end

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: everything sent, every result back, then a short tail.
    while (req_q.size() != 0 || s_axis_tvalid_i || pending_rsp_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Input driver: offers the next queued beat once the previous one is taken.
  always @(negedge clk_i) begin
    logic offer;
    int   idle_pct;
    table_req_t nxt_req;
    if (rst_ni && (!s_axis_tvalid_i || in_beat_taken)) begin
      offer    = 1'b0;
      idle_pct = (accepted_count < PhaseLen) ? 31 : (accepted_count < 2 * PhaseLen) ? 79 : 0;
      if (req_q.size() != 0 && !(req_q[0].wait_drain && pending_rsp_q.size() != 0) &&
          $urandom_range(99) >= idle_pct) begin
        nxt_req = req_q.pop_front();
        s_axis_tuser_i <= nxt_req.op;
        s_axis_tdata_i <= {6'd0, nxt_req.move, nxt_req.bound, nxt_req.score,
                           nxt_req.depth, nxt_req.key};
        offer = 1'b1;
      end
      s_axis_tvalid_i <= offer;
    end
  end

  // Result receiver: random back-pressure plus one long hold-off.
  always @(negedge clk_i) begin
    int idle_pct;
    if (rst_ni) begin
      idle_pct = (accepted_count < PhaseLen) ? 79 : (accepted_count < 2 * PhaseLen) ? 31 : 0;
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!rx_hold_done && accepted_count >= HoldAt) begin
        rx_hold_done = 1'b1;
        rx_hold_left = HoldCycles;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Monitor: predicts on each input beat and checks each result beat.
  always @(posedge clk_i) begin
    table_req_t seen_req;
    table_rsp_t want;
    entry_t     got;
    in_beat_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (in_beat_taken) begin
      seen_req.op         = s_axis_tuser_i;
      seen_req.key        = s_axis_tdata_i[63:0];
      seen_req.depth      = s_axis_tdata_i[71:64];
      seen_req.score      = s_axis_tdata_i[87:72];
      seen_req.bound      = s_axis_tdata_i[89:88];
      seen_req.move       = s_axis_tdata_i[105:90];
      seen_req.wait_drain = 1'b0;
      apply_to_shadow_table(seen_req, want);
      pending_rsp_q.push_back(want);
      accepted_count++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("%0t: result beat with nothing expected: tuser %0h tdata %0h",
                   $time, m_axis_tuser_o, m_axis_tdata_o);
        end
      end else begin
        want = pending_rsp_q.pop_front();
        got  = entry_t'(m_axis_tdata_o);
        check_field("hit", 32'(want.hit), 32'(m_axis_tuser_o[0]));
        check_field("written", 32'(want.written), 32'(m_axis_tuser_o[1]));
        check_field("move_out", 32'(want.data.move), 32'(got.move));
        check_field("score_out", 32'(want.data.score), 32'(got.score));
        check_field("depth_out", 32'(want.data.depth), 32'(got.depth));
        check_field("bound_out", 32'(want.data.bound), 32'(got.bound));
        check_field("age_out", 32'(want.data.age), 32'(got.age));
      end
    end
  end

endmodule
